// ===== hw/rtl/star_tracker_pixel_to_unit_vector_top_macros.svh =====
// Assertion macros for the star tracker spot-to-vector block.
// Used by the divider stage and the top level; no other dependencies.
`ifndef STAR_TRACKER_PIXEL_TO_UNIT_VECTOR_TOP_MACROS_SVH
`define STAR_TRACKER_PIXEL_TO_UNIT_VECTOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define STP_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define STP_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define STP_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define STP_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/stp_pkg.sv =====
// Shared widths, register indexes and inter-stage types for the spot-to-vector block.
// No dependencies.
package stp_pkg;

  localparam int PosW     = 20;  // Q12.8 pixel positions
  localparam int OffW     = 21;  // signed offsets from center
  localparam int CoefW    = 32;
  localparam int RadOffW  = 20;
  localparam int FocW     = 24;
  localparam int DirW     = 32;
  localparam int DirZW    = 31;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int MagW     = 64;  // corrected magnitudes, 2^-40 px
  localparam int NrmW     = 31;  // normalized magnitudes
  localparam int RootW    = 32;  // norm

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CENTER_H   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTER_V   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LIN_COEF_H = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LIN_COEF_V = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RAD_COEF   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RAD_OFFSET = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FOCAL_LEN  = 3'd6;

  typedef struct packed {
    logic        [PosW-1:0]    center_h;
    logic        [PosW-1:0]    center_v;
    logic signed [CoefW-1:0]   lin_coef_h;
    logic signed [CoefW-1:0]   lin_coef_v;
    logic signed [CoefW-1:0]   rad_coef;
    logic signed [RadOffW-1:0] rad_offset;
    logic        [FocW-1:0]    focal_len;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_h:   20'd524288,
    center_v:   20'd524288,
    lin_coef_h: 32'sd0,
    lin_coef_v: 32'sd0,
    rad_coef:   32'sd0,
    rad_offset: 20'sd0,
    focal_len:  24'd1048576
  };

  // front end -> normalizer
  typedef struct packed {
    logic            negx;
    logic            negy;
    logic [MagW-1:0] ax;
    logic [MagW-1:0] ay;
  } corr_t;

  // normalizer -> divider
  typedef struct packed {
    logic             zero;
    logic             negx;
    logic             negy;
    logic [NrmW-1:0]  ax;
    logic [NrmW-1:0]  ay;
    logic [NrmW-1:0]  az;
    logic [RootW-1:0] n;
  } nrm_t;

  // divider -> output stage
  typedef struct packed {
    logic            zero;
    logic            negx;
    logic            negy;
    logic [NrmW-1:0] mx;
    logic [NrmW-1:0] my;
    logic [NrmW-1:0] mz;
  } res_t;

endpackage

// ===== hw/rtl/stp_front.sv =====
// Front end: center offsets, radius square root, distortion gain, corrected offsets.
// Depends on stp_pkg.
module stp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [stp_pkg::PosW-1:0]  spot_h,
  input  logic [stp_pkg::PosW-1:0]  spot_v,
  input  stp_pkg::cfg_t             cfg,
  output logic                      out_valid,
  output stp_pkg::corr_t            out_data
);
  import stp_pkg::*;

  localparam int SqW   = 41;            // dh^2 + dv^2
  localparam int LinW  = CoefW + OffW + 1;
  localparam int R1M   = 29;            // root bits, units 2^-16 px
  localparam int R1X   = 2 * R1M;
  localparam int R1RW  = R1M + 3;
  localparam int GW    = 58;            // gain in 2^-48
  localparam int G32W  = GW - 16;
  localparam int GLoW  = 21;
  localparam logic signed [GW-1:0] GAIN_ONE = GW'(1) << 48;

  typedef struct packed {
    logic signed [OffW-1:0] dh;
    logic signed [OffW-1:0] dv;
    logic signed [LinW-1:0] lin;
    logic        [R1X-1:0]  x;
    logic        [R1RW-1:0] rem;
    logic        [R1M-1:0]  root;
  } sq1_t;

  // stage F0: offsets
  logic v0;
  logic signed [OffW-1:0] dh0, dv0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dh0 <= $signed({1'b0, spot_h}) - $signed({1'b0, cfg.center_h});
      dv0 <= $signed({1'b0, spot_v}) - $signed({1'b0, cfg.center_v});
    end
  end

  // stage F1: squares and linear terms, loads the root pipeline
  logic signed [2*OffW-1:0]     dh_sq, dv_sq;
  logic signed [CoefW+OffW-1:0] lhd, lvd;
  logic        [SqW-1:0]        sq;
  assign dh_sq = dh0 * dh0;
  assign dv_sq = dv0 * dv0;
  assign lhd   = cfg.lin_coef_h * dh0;
  assign lvd   = cfg.lin_coef_v * dv0;
  assign sq    = dh_sq[SqW-1:0] + dv_sq[SqW-1:0];

  sq1_t s1  [R1M+1];
  logic s1v [R1M+1];

  always_ff @(posedge clk) begin
    if (rst) s1v[0] <= 1'b0;
    else if (en) s1v[0] <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1[0].dh   <= dh0;
      s1[0].dv   <= dv0;
      s1[0].lin  <= $signed({lhd[CoefW+OffW-1], lhd}) + $signed({lvd[CoefW+OffW-1], lvd});
      s1[0].x    <= {1'b0, sq, 16'd0};
      s1[0].rem  <= '0;
      s1[0].root <= '0;
    end
  end

  // radius root, one result bit per stage
  for (genvar k = 0; k < R1M; k++) begin : g_root
    logic [R1RW-1:0] cur, trial;
    sq1_t nxt;
    assign cur   = {s1[k].rem[R1RW-3:0], s1[k].x[R1X-1 -: 2]};
    assign trial = R1RW'({s1[k].root, 2'b01});
    always_comb begin
      nxt   = s1[k];
      nxt.x = s1[k].x << 2;
      if (cur >= trial) begin
        nxt.rem  = cur - trial;
        nxt.root = {s1[k].root[R1M-2:0], 1'b1};
      end else begin
        nxt.rem  = cur;
        nxt.root = {s1[k].root[R1M-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) s1v[k+1] <= 1'b0;
      else if (en) s1v[k+1] <= s1v[k];
    end
    always_ff @(posedge clk) begin
      if (en) s1[k+1] <= nxt;
    end
  end

  // stage F2: r * (r + offset)
  logic signed [29:0] tsum;
  logic signed [58:0] pprod;
  assign tsum  = $signed({1'b0, s1[R1M].root})
               + $signed({{2{cfg.rad_offset[RadOffW-1]}}, cfg.rad_offset, 8'd0});
  assign pprod = $signed({1'b0, s1[R1M].root}) * tsum;

  logic v2;
  logic signed [58:0]     p2;
  logic signed [OffW-1:0] dh2, dv2;
  logic signed [LinW-1:0] lin2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= s1v[R1M];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p2   <= pprod;
      dh2  <= s1[R1M].dh;
      dv2  <= s1[R1M].dv;
      lin2 <= s1[R1M].lin;
    end
  end

  // stage F3: coefficient times high and low words of the product
  logic signed [58:0] rch;
  logic signed [64:0] rcl;
  assign rch = cfg.rad_coef * $signed(p2[58:32]);
  assign rcl = cfg.rad_coef * $signed({1'b0, p2[31:0]});

  logic v3;
  logic signed [58:0]     rch3;
  logic signed [64:0]     rcl3;
  logic signed [OffW-1:0] dh3, dv3;
  logic signed [LinW-1:0] lin3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rch3 <= rch;
      rcl3 <= rcl;
      dh3  <= dh2;
      dv3  <= dv2;
      lin3 <= lin2;
    end
  end

  // stage F4: gain sum, floored to 2^-32
  logic signed [59:0] rsum;
  logic signed [GW-1:0] g48;
  assign rsum = rch3 + $signed(rcl3[64:32]);
  assign g48  = GAIN_ONE + lin3 + $signed(rsum[59:4]);

  logic v4;
  logic signed [G32W-1:0] g4;
  logic signed [OffW-1:0] dh4, dv4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g4  <= g48[GW-1:16];
      dh4 <= dh3;
      dv4 <= dv3;
    end
  end

  // stage F5: offset times gain, gain split in two halves
  logic signed [OffW+GLoW:0]      phl, pvl;
  logic signed [OffW+G32W-GLoW-1:0] phh, pvh;
  assign phl = dh4 * $signed({1'b0, g4[GLoW-1:0]});
  assign pvl = dv4 * $signed({1'b0, g4[GLoW-1:0]});
  assign phh = dh4 * $signed(g4[G32W-1:GLoW]);
  assign pvh = dv4 * $signed(g4[G32W-1:GLoW]);

  logic v5;
  logic signed [OffW+GLoW:0]        phl5, pvl5;
  logic signed [OffW+G32W-GLoW-1:0] phh5, pvh5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      phl5 <= phl;
      pvl5 <= pvl;
      phh5 <= phh;
      pvh5 <= pvh;
    end
  end

  // stage F6: recombine partial products
  logic signed [MagW-1:0] chs, cvs;
  assign chs = $signed({phh5[OffW+G32W-GLoW-1], phh5, 21'd0}) + phl5;
  assign cvs = $signed({pvh5[OffW+G32W-GLoW-1], pvh5, 21'd0}) + pvl5;

  logic v6;
  logic signed [MagW-1:0] ch6, cv6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ch6 <= chs;
      cv6 <= cvs;
    end
  end

  // stage F7: magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.negx <= !cv6[MagW-1] && (cv6 != '0);
      out_data.negy <= ch6[MagW-1];
      out_data.ax   <= cv6[MagW-1] ? MagW'(-cv6) : MagW'(cv6);
      out_data.ay   <= ch6[MagW-1] ? MagW'(-ch6) : MagW'(ch6);
    end
  end

endmodule

// ===== hw/rtl/stp_norm.sv =====
// Normalizer: common power-of-two scaling, sum of squares and norm square root.
// Depends on stp_pkg.
module stp_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  stp_pkg::corr_t in_data,
  input  logic [stp_pkg::FocW-1:0] focal_len,
  output logic           out_valid,
  output stp_pkg::nrm_t  out_data
);
  import stp_pkg::*;

  localparam int R2X  = 2 * RootW;
  localparam int R2RW = RootW + 3;
  localparam int SqrW = 2 * NrmW;

  typedef struct packed {
    logic            negx;
    logic            negy;
    logic [MagW-1:0] a;
    logic [MagW-1:0] b;
    logic [MagW-1:0] c;
    logic [MagW-1:0] o;
  } nm_t;

  typedef struct packed {
    logic             zero;
    logic             negx;
    logic             negy;
    logic [NrmW-1:0]  ax;
    logic [NrmW-1:0]  ay;
    logic [NrmW-1:0]  az;
    logic [R2X-1:0]   x;
    logic [R2RW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq2_t;

  // shift all three left by sh when the top sh bits of their OR are clear
  function automatic nm_t nm_shift(nm_t s, int unsigned sh);
    nm_t r;
    r = s;
    if ((s.o >> (MagW - sh)) == '0) begin
      r.a = s.a << sh;
      r.b = s.b << sh;
      r.c = s.c << sh;
      r.o = s.o << sh;
    end
    return r;
  endfunction

  // stage NA: load and shift by 32, 16
  nm_t na_in, na, nb, nc;
  logic va, vb, vc;
  always_comb begin
    na_in.negx = in_data.negx;
    na_in.negy = in_data.negy;
    na_in.a    = in_data.ax;
    na_in.b    = in_data.ay;
    na_in.c    = {8'd0, focal_len, 32'd0};
    na_in.o    = in_data.ax | in_data.ay | na_in.c;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      na <= nm_shift(nm_shift(na_in, 32), 16);
      nb <= nm_shift(nm_shift(na, 8), 4);
      nc <= nm_shift(nm_shift(nb, 2), 1);
    end
  end

  // stage ND: take normalized magnitudes and square them
  logic [NrmW-1:0] ax_n, ay_n, az_n;
  logic [SqrW-1:0] sqx, sqy, sqz;
  assign ax_n = nc.a[MagW-1 -: NrmW];
  assign ay_n = nc.b[MagW-1 -: NrmW];
  assign az_n = nc.c[MagW-1 -: NrmW];
  assign sqx  = ax_n * ax_n;
  assign sqy  = ay_n * ay_n;
  assign sqz  = az_n * az_n;

  logic vd, zd, nxd, nyd;
  logic [NrmW-1:0] axd, ayd, azd;
  logic [SqrW-1:0] sqxd, sqyd, sqzd;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= vc;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zd   <= (nc.o == '0);
      nxd  <= nc.negx;
      nyd  <= nc.negy;
      axd  <= ax_n;
      ayd  <= ay_n;
      azd  <= az_n;
      sqxd <= sqx;
      sqyd <= sqy;
      sqzd <= sqz;
    end
  end

  // stage NE: sum of squares loads the root pipeline
  sq2_t s2  [RootW+1];
  logic s2v [RootW+1];
  always_ff @(posedge clk) begin
    if (rst) s2v[0] <= 1'b0;
    else if (en) s2v[0] <= vd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2[0].zero <= zd;
      s2[0].negx <= nxd;
      s2[0].negy <= nyd;
      s2[0].ax   <= axd;
      s2[0].ay   <= ayd;
      s2[0].az   <= azd;
      s2[0].x    <= {2'b0, sqxd} + {2'b0, sqyd} + {2'b0, sqzd};
      s2[0].rem  <= '0;
      s2[0].root <= '0;
    end
  end

  // norm root, one bit per stage
  for (genvar k = 0; k < RootW; k++) begin : g_root
    logic [R2RW-1:0] cur, trial;
    sq2_t nxt;
    assign cur   = {s2[k].rem[R2RW-3:0], s2[k].x[R2X-1 -: 2]};
    assign trial = R2RW'({s2[k].root, 2'b01});
    always_comb begin
      nxt   = s2[k];
      nxt.x = s2[k].x << 2;
      if (cur >= trial) begin
        nxt.rem  = cur - trial;
        nxt.root = {s2[k].root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = cur;
        nxt.root = {s2[k].root[RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) s2v[k+1] <= 1'b0;
      else if (en) s2v[k+1] <= s2v[k];
    end
    always_ff @(posedge clk) begin
      if (en) s2[k+1] <= nxt;
    end
  end

  assign out_valid     = s2v[RootW];
  assign out_data.zero = s2[RootW].zero;
  assign out_data.negx = s2[RootW].negx;
  assign out_data.negy = s2[RootW].negy;
  assign out_data.ax   = s2[RootW].ax;
  assign out_data.ay   = s2[RootW].ay;
  assign out_data.az   = s2[RootW].az;
  assign out_data.n    = s2[RootW].root;

endmodule

// ===== hw/rtl/stp_div.sv =====
// Divider: three restoring division lanes sharing the norm, then rounding.
// Depends on stp_pkg and the assertion macro header.
`include "star_tracker_pixel_to_unit_vector_top_macros.svh"
module stp_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  stp_pkg::nrm_t in_data,
  output logic          out_valid,
  output stp_pkg::res_t out_data
);
  import stp_pkg::*;

  localparam int QW = RootW;       // quotient bits
  localparam int RW = RootW + 1;   // partial remainder

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic             zero;
    logic             negx;
    logic             negy;
    logic [RootW-1:0] n;
    lane_t            lx;
    lane_t            ly;
    lane_t            lz;
  } dv_t;

  // one quotient bit; the first step does not double the remainder
  function automatic lane_t lane_step(lane_t l, logic [RootW-1:0] n, logic first);
    lane_t r;
    logic [RW-1:0] sh;
    sh = first ? l.rem : {l.rem[RW-2:0], 1'b0};
    if (sh >= {1'b0, n}) begin
      r.rem = sh - {1'b0, n};
      r.q   = {l.q[QW-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.q   = {l.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic lane_t lane_load(logic [NrmW-1:0] a);
    lane_t r;
    r.rem = RW'(a);
    r.q   = '0;
    return r;
  endfunction

  dv_t  d  [QW];
  logic dvv[QW];

  // first stage: quotient bit 31
  always_ff @(posedge clk) begin
    if (rst) dvv[0] <= 1'b0;
    else if (en) dvv[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d[0].zero <= in_data.zero;
      d[0].negx <= in_data.negx;
      d[0].negy <= in_data.negy;
      d[0].n    <= in_data.n;
      d[0].lx   <= lane_step(lane_load(in_data.ax), in_data.n, 1'b1);
      d[0].ly   <= lane_step(lane_load(in_data.ay), in_data.n, 1'b1);
      d[0].lz   <= lane_step(lane_load(in_data.az), in_data.n, 1'b1);
    end
  end

  // remaining quotient bits
  for (genvar k = 0; k < QW - 1; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dvv[k+1] <= 1'b0;
      else if (en) dvv[k+1] <= dvv[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d[k+1].zero <= d[k].zero;
        d[k+1].negx <= d[k].negx;
        d[k+1].negy <= d[k].negy;
        d[k+1].n    <= d[k].n;
        d[k+1].lx   <= lane_step(d[k].lx, d[k].n, 1'b0);
        d[k+1].ly   <= lane_step(d[k].ly, d[k].n, 1'b0);
        d[k+1].lz   <= lane_step(d[k].lz, d[k].n, 1'b0);
      end
    end
  end

  // rounding: (q + 1) / 2
  logic [QW:0] rx, ry, rz;
  assign rx = {1'b0, d[QW-1].lx.q} + (QW+1)'(1);
  assign ry = {1'b0, d[QW-1].ly.q} + (QW+1)'(1);
  assign rz = {1'b0, d[QW-1].lz.q} + (QW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dvv[QW-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.zero <= d[QW-1].zero;
      out_data.negx <= d[QW-1].negx;
      out_data.negy <= d[QW-1].negy;
      out_data.mx   <= rx[NrmW:1];
      out_data.my   <= ry[NrmW:1];
      out_data.mz   <= rz[NrmW:1];
    end
  end

  // a component never exceeds the norm, so no magnitude exceeds one
  `STP_ASSERT_IMP(a_div_unit_bound, clk, rst, out_valid && !out_data.zero, (out_data.mx <= 31'h4000_0000) && (out_data.my <= 31'h4000_0000) && (out_data.mz <= 31'h4000_0000), "divider magnitude above one")

endmodule

// ===== hw/rtl/star_tracker_pixel_to_unit_vector_top.sv =====
// Top level: calibration registers, front end, normalizer, divider, output skid.
// Depends on stp_pkg, stp_front, stp_norm, stp_div and the assertion macro header.
//
//   channel  signals                                   dir  item
//   in       in_valid/in_ready, spot_h, spot_v         in   one spot
//   out      out_valid/out_ready, dir_x, dir_y, dir_z  out  one unit vector
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in   one register write
//
// One spot per cycle while the skid slot is empty; the path from acceptance to out_valid
// runs through the 29-stage radius root, the 32-stage norm root and the 32-stage dividers.
// Reset clears all valid bits and loads the calibration reset values.
// The pipeline advances whenever the skid slot is empty, so one result may wait
// at the output while spots keep entering; cfg_ready is always high.
`include "star_tracker_pixel_to_unit_vector_top_macros.svh"
module star_tracker_pixel_to_unit_vector_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [stp_pkg::PosW-1:0]         spot_h,
  input  logic [stp_pkg::PosW-1:0]         spot_v,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [stp_pkg::DirW-1:0]  dir_x,
  output logic signed [stp_pkg::DirW-1:0]  dir_y,
  output logic [stp_pkg::DirZW-1:0]        dir_z,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [stp_pkg::CfgDataW-1:0]     cfg_data
);
  import stp_pkg::*;

  typedef struct packed {
    logic signed [DirW-1:0] dx;
    logic signed [DirW-1:0] dy;
    logic [DirZW-1:0]       dz;
  } out_t;

  cfg_t  cfg;
  logic  en;
  logic  fv, nv, rv;
  corr_t fd;
  nrm_t  nd;
  res_t  rd;
  out_t  res_out, od, sd;
  logic  ov, sv, take, push;

  // calibration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_H:   cfg.center_h   <= cfg_data[PosW-1:0];
        REG_CENTER_V:   cfg.center_v   <= cfg_data[PosW-1:0];
        REG_LIN_COEF_H: cfg.lin_coef_h <= cfg_data[CoefW-1:0];
        REG_LIN_COEF_V: cfg.lin_coef_v <= cfg_data[CoefW-1:0];
        REG_RAD_COEF:   cfg.rad_coef   <= cfg_data[CoefW-1:0];
        REG_RAD_OFFSET: cfg.rad_offset <= cfg_data[RadOffW-1:0];
        REG_FOCAL_LEN:  cfg.focal_len  <= cfg_data[FocW-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !sv;
  assign in_ready = en;

  stp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .spot_h    (spot_h),
    .spot_v    (spot_v),
    .cfg       (cfg),
    .out_valid (fv),
    .out_data  (fd)
  );

  stp_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv),
    .in_data   (fd),
    .focal_len (cfg.focal_len),
    .out_valid (nv),
    .out_data  (nd)
  );

  stp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (nv),
    .in_data   (nd),
    .out_valid (rv),
    .out_data  (rd)
  );

  // apply signs, zero vector for zero norm
  always_comb begin
    res_out.dx = '0;
    res_out.dy = '0;
    res_out.dz = '0;
    if (!rd.zero) begin
      res_out.dx = rd.negx ? -$signed({1'b0, rd.mx}) : $signed({1'b0, rd.mx});
      res_out.dy = rd.negy ? -$signed({1'b0, rd.my}) : $signed({1'b0, rd.my});
      res_out.dz = rd.mz;
    end
  end

  // output register plus one skid slot
  assign take = ov && out_ready;
  assign push = en && rv;
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (!ov || take) begin
        od <= sd;
        ov <= 1'b1;
        sv <= 1'b0;
      end
    end else if (push) begin
      if (!ov || take) begin
        od <= res_out;
        ov <= 1'b1;
      end else begin
        sd <= res_out;
        sv <= 1'b1;
      end
    end else if (take) begin
      ov <= 1'b0;
    end
  end

  assign out_valid = ov;
  assign dir_x     = od.dx;
  assign dir_y     = od.dy;
  assign dir_z     = od.dz;

  `STP_ASSERT_IMP(a_skid_behind_out, clk, rst, sv, ov, "skid slot full with output empty")
  `STP_ASSERT_NXT(a_skid_catches, clk, rst, ov && !out_ready && !sv && rv, sv, "stalled item not caught by skid")
  `STP_ASSERT_NXT(a_skid_drains, clk, rst, sv && out_ready, ov && !sv, "skid slot not moved to output")

endmodule
